// ----- rtl/amsd_pkg.sv -----
// Shared types and constants for the accelerometer motion/shake detector.
// No dependencies; imported by every module of the block.
package amsd_pkg;

  localparam int RAW_W      = 16;
  localparam int AXIS_W     = 12;
  localparam int SQ_W       = 23;   // (-2048)^2 needs 23 bits
  localparam int SUM_W      = 24;   // three squares
  localparam int ROOT_W     = 32;
  localparam int MAG_W      = 12;
  localparam int ROOT_STEPS = 16;
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [ROOT_W-1:0] ROOT_TOP = ROOT_W'(32'h4000_0000);

  localparam logic [MAG_W-1:0] REST_MG   = MAG_W'(1000);
  localparam logic [MAG_W-1:0] SLOW_AT   = MAG_W'(140);
  localparam logic [MAG_W-1:0] MEDIUM_AT = MAG_W'(280);
  localparam logic [MAG_W-1:0] FAST_AT   = MAG_W'(420);

  localparam logic [MAG_W-1:0]  SHAKE_LEVEL_RST = MAG_W'(420);
  localparam logic [TIME_W-1:0] HOLD_OFF_RST    = TIME_W'(1000);

  localparam logic [1:0] MODE_CLASS = 2'd1;
  localparam logic [1:0] MODE_SHAKE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_LEVEL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_OFF    = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_READ_FAIL = 2'd1,
    STATUS_SKIP      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_SLOW   = 2'd1,
    CLS_MEDIUM = 2'd2,
    CLS_FAST   = 2'd3
  } class_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_MERGE,
    FSM_ROOT,
    FSM_EMIT
  } fsm_e;

  // handshake between controller and root unit
  typedef struct packed {
    logic start;
  } root_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } root_sts_t;

endpackage

// ----- rtl/accel_motion_shake_detector.sv -----
// Top level: three axis lanes, merge adder, root unit, motion/shake logic.
// Depends on amsd_pkg, amsd_lane, amsd_isqrt.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one three-axis sample
//   with mode, sample_good and time_ms. Output channel (out_valid_o /
//   out_stall_i) returns exactly one result beat per input beat, in order.
//   Config port: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 shake_level, 1 hold_off_time); other indexes are ignored.
//   A good sample goes through the merge and root load, sixteen root
//   steps, a wait to see done and the emit state before out_valid_o
//   rises; a skipped or failed read goes straight to the emit state.
//   One item is in flight at a time: a new sample is taken only after
//   the last result is emitted, so good samples are paced by the
//   sixteen-step root unit.
//   The output register parts the channels: a new sample is taken while a
//   result still waits; if the receiver stalls, the next result holds in
//   the emit cycle until the output register frees.
//   Reset: shake_level 420, hold_off_time 1000, previous magnitude 1000
//   (not yet known), no shake recorded, output empty.
module accel_motion_shake_detector (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [amsd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [amsd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         mode_i,
  input  logic signed [amsd_pkg::RAW_W-1:0]  raw_x_i,
  input  logic signed [amsd_pkg::RAW_W-1:0]  raw_y_i,
  input  logic signed [amsd_pkg::RAW_W-1:0]  raw_z_i,
  input  logic                               sample_good_i,
  input  logic [amsd_pkg::TIME_W-1:0]        time_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic signed [amsd_pkg::AXIS_W-1:0] scaled_x_o,
  output logic signed [amsd_pkg::AXIS_W-1:0] scaled_y_o,
  output logic signed [amsd_pkg::AXIS_W-1:0] scaled_z_o,
  output logic [amsd_pkg::MAG_W-1:0]         magnitude_o,
  output logic [amsd_pkg::MAG_W-1:0]         activity_level_o,
  output logic [1:0]                         motion_class_o,
  output logic                               shake_fired_o
);
  import amsd_pkg::*;

  fsm_e fsm_q, fsm_d;

  // config
  logic [MAG_W-1:0]  shake_level_q;
  logic [TIME_W-1:0] hold_off_q;

  // detector state
  logic [MAG_W-1:0]  prev_mag_q;
  logic              prev_known_q;
  logic [TIME_W-1:0] last_shake_q;

  // item in flight
  logic [1:0]        mode_q;
  logic [TIME_W-1:0] time_q;
  status_e           status_q, status_d;

  // lanes and root
  logic                     accept, skip;
  logic signed [AXIS_W-1:0] sx, sy, sz;
  logic [SQ_W-1:0]          qx, qy, qz;
  logic [SUM_W-1:0]         sum;
  root_ctl_t                root_ctl;
  root_sts_t                root_sts;
  logic [MAG_W-1:0]         mag;

  // motion logic
  logic [MAG_W-1:0] dev, jerk, act;
  class_e           cls;
  logic             is_act, fire, emit, out_free;

  // output register
  logic                     out_valid_q, out_valid_d;
  status_e                  o_status_q;
  logic signed [AXIS_W-1:0] o_sx_q, o_sy_q, o_sz_q;
  logic [MAG_W-1:0]         o_mag_q, o_act_q;
  class_e                   o_cls_q;
  logic                     o_fire_q;

  assign in_stall_o = fsm_q != FSM_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign skip       = (mode_i == MODE_SHAKE) && (last_shake_q != '0) &&
                      ((time_ms_i - last_shake_q) < hold_off_q);

  amsd_lane u_lane_x (.clk_i, .load_i(accept), .raw_i(raw_x_i), .scaled_o(sx), .square_o(qx));
  amsd_lane u_lane_y (.clk_i, .load_i(accept), .raw_i(raw_y_i), .scaled_o(sy), .square_o(qy));
  amsd_lane u_lane_z (.clk_i, .load_i(accept), .raw_i(raw_z_i), .scaled_o(sz), .square_o(qz));

  // merge the lane squares
  assign sum = SUM_W'(qx) + SUM_W'(qy) + SUM_W'(qz);

  amsd_isqrt u_isqrt (
    .clk_i,
    .rst_ni,
    .ctl_i   (root_ctl),
    .value_i (sum),
    .sts_o   (root_sts),
    .root_o  (mag)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    fsm_d          = fsm_q;
    root_ctl.start = 1'b0;
    emit           = 1'b0;
    status_d       = STATUS_OK;
    if (skip)               status_d = STATUS_SKIP;
    else if (!sample_good_i) status_d = STATUS_READ_FAIL;
    unique case (fsm_q)
      FSM_IDLE: begin
        if (accept) fsm_d = (status_d == STATUS_OK) ? FSM_MERGE : FSM_EMIT;
      end
      FSM_MERGE: begin
        root_ctl.start = 1'b1;
        fsm_d          = FSM_ROOT;
      end
      FSM_ROOT: begin
        if (root_sts.done) fsm_d = FSM_EMIT;
      end
      FSM_EMIT: begin
        if (out_free) begin
          emit  = 1'b1;
          fsm_d = FSM_IDLE;
        end
      end
      default: fsm_d = FSM_IDLE;
    endcase
  end

  // activity, class and shake decision
  always_comb begin
    dev  = (mag >= REST_MG) ? mag - REST_MG : REST_MG - mag;
    jerk = '0;
    if (prev_known_q) jerk = (mag >= prev_mag_q) ? mag - prev_mag_q : prev_mag_q - mag;
    act = (dev > jerk) ? dev : jerk;
    priority if (act < SLOW_AT)   cls = CLS_NONE;
    else if (act < MEDIUM_AT)     cls = CLS_SLOW;
    else if (act < FAST_AT)       cls = CLS_MEDIUM;
    else                          cls = CLS_FAST;
    is_act = (status_q == STATUS_OK) && (mode_q == MODE_CLASS || mode_q == MODE_SHAKE);
    fire   = is_act && (mode_q == MODE_SHAKE) &&
             (cls == CLS_FAST || act >= shake_level_q);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit)             out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q         <= FSM_IDLE;
      out_valid_q   <= 1'b0;
      shake_level_q <= SHAKE_LEVEL_RST;
      hold_off_q    <= HOLD_OFF_RST;
      prev_mag_q    <= REST_MG;
      prev_known_q  <= 1'b0;
      last_shake_q  <= '0;
    end else begin
      fsm_q       <= fsm_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SHAKE_LEVEL: shake_level_q <= cfg_data_i[MAG_W-1:0];
          CFG_HOLD_OFF:    hold_off_q    <= cfg_data_i[TIME_W-1:0];
          default: ;
        endcase
      end
      if (emit && is_act) begin
        prev_mag_q   <= mag;
        prev_known_q <= 1'b1;
        if (fire) last_shake_q <= (time_q == '0) ? TIME_W'(1) : time_q;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_i;
      time_q   <= time_ms_i;
      status_q <= status_d;
    end
    if (emit) begin
      o_status_q <= status_q;
      o_sx_q     <= (status_q == STATUS_OK) ? sx : '0;
      o_sy_q     <= (status_q == STATUS_OK) ? sy : '0;
      o_sz_q     <= (status_q == STATUS_OK) ? sz : '0;
      o_mag_q    <= (status_q == STATUS_OK) ? mag : '0;
      o_act_q    <= is_act ? act : '0;
      o_cls_q    <= is_act ? cls : CLS_NONE;
      o_fire_q   <= fire;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = o_status_q;
  assign scaled_x_o       = o_sx_q;
  assign scaled_y_o       = o_sy_q;
  assign scaled_z_o       = o_sz_q;
  assign magnitude_o      = o_mag_q;
  assign activity_level_o = o_act_q;
  assign motion_class_o   = o_cls_q;
  assign shake_fired_o    = o_fire_q;

endmodule

// ----- rtl/amsd_lane.sv -----
// One axis lane: arithmetic shift by four and registered square.
// Depends on amsd_pkg.
module amsd_lane (
  input  logic                             clk_i,
  input  logic                             load_i,
  input  logic signed [amsd_pkg::RAW_W-1:0]  raw_i,
  output logic signed [amsd_pkg::AXIS_W-1:0] scaled_o,
  output logic        [amsd_pkg::SQ_W-1:0]   square_o
);
  import amsd_pkg::*;

  logic signed [AXIS_W-1:0]   scaled_d, scaled_q;
  logic signed [2*AXIS_W-1:0] prod;
  logic        [SQ_W-1:0]     square_q;

  // >>> 4 of a 16-bit word is just its top 12 bits
  assign scaled_d = raw_i[RAW_W-1:RAW_W-AXIS_W];
  assign prod     = scaled_d * scaled_d;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      scaled_q <= scaled_d;
      square_q <= prod[SQ_W-1:0];
    end
  end

  assign scaled_o = scaled_q;
  assign square_o = square_q;

endmodule

// ----- rtl/amsd_isqrt.sv -----
// Bit-pair integer square root, one step per cycle, sixteen steps.
// Depends on amsd_pkg.
module amsd_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  amsd_pkg::root_ctl_t           ctl_i,
  input  logic [amsd_pkg::SUM_W-1:0]    value_i,
  output amsd_pkg::root_sts_t           sts_o,
  output logic [amsd_pkg::MAG_W-1:0]    root_o
);
  import amsd_pkg::*;

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [ROOT_W-1:0] v_q, r_q, bit_q;
  logic [ROOT_W-1:0] trial;
  logic              take, last;

  assign trial = r_q + bit_q;
  assign take  = v_q >= trial;
  assign last  = cnt_q == STEP_W'(ROOT_STEPS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + STEP_W'(1);
        if (last) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      v_q   <= {{(ROOT_W-SUM_W){1'b0}}, value_i};
      r_q   <= '0;
      bit_q <= ROOT_TOP;
    end else if (busy_q) begin
      if (take) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign root_o     = r_q[MAG_W-1:0];

endmodule

// ----- rtl/amsd_checker.sv -----
// Port-level checks for the detector, bound to the top level.
// Depends on amsd_pkg and accel_motion_shake_detector.
module amsd_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [1:0]                         status_o,
  input logic [amsd_pkg::MAG_W-1:0]         magnitude_o,
  input logic [amsd_pkg::MAG_W-1:0]         activity_level_o,
  input logic [1:0]                         motion_class_o,
  input logic                               shake_fired_o
);
  import amsd_pkg::*;

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(magnitude_o))
    else $error("stalled output beat changed");

  // one item in flight: busy right after an input beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in flight");

  // skipped or failed beats carry no measurement
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |->
      magnitude_o == '0 && activity_level_o == '0 && !shake_fired_o)
    else $error("non-ok beat carries data");

  // fast class matches its activity threshold
  a_fast_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motion_class_o == CLS_FAST |-> activity_level_o >= FAST_AT)
    else $error("fast class below threshold");

  // a fired shake implies a good beat
  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && shake_fired_o |-> status_o == STATUS_OK)
    else $error("shake fired on a non-ok beat");

endmodule

bind accel_motion_shake_detector amsd_checker u_amsd_checker (.*);
